// ===== rtl/core/wfa_pkg.sv =====
`default_nettype none
package wfa_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;

   localparam int IDX_BITS = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] entry_size;
      logic [15:0] request_size;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [4:0]  block_number;
      logic [15:0] block_size;
      logic [15:0] asked_size;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

   typedef struct packed {
      logic     en;
      idx_type  addr;
      size_type data;
   } ram_wr_type;

   function automatic size_type to_size(logic [15:0] v);
      logic [47:0] w;
      w = {32'd0, v};
      return w[SIZE_BITS-1:0];
   endfunction

   function automatic logic [15:0] from_size(size_type s);
      logic [31:0] w;
      w = 32'(s);
      return w[15:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wfa_size_ram.sv =====
`default_nettype none
module wfa_size_ram (
   input  wire logic                clock,
   input  wire wfa_pkg::ram_wr_type wr,
   input  wire wfa_pkg::idx_type    raddr,
   output wfa_pkg::size_type        rdata
);

   wfa_pkg::size_type mem [wfa_pkg::MAX_BLOCKS];
   wfa_pkg::size_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/wfa_ctrl.sv =====
`default_nettype none
module wfa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire wfa_pkg::req_type    req_data,
   output logic                     req_stall,
   input  wire logic                out_free,
   output wfa_pkg::res_type         result,
   output wfa_pkg::ram_wr_type      ram_wr,
   output wfa_pkg::idx_type         ram_raddr,
   input  wire wfa_pkg::size_type   ram_rdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                      state_ff, state_in;
   wfa_pkg::cnt_type                count_ff, count_in;
   logic [wfa_pkg::MAX_BLOCKS-1:0]  marks_ff, marks_in;
   wfa_pkg::cnt_type                scan_ff, scan_in;
   logic                            rd_pend_ff, rd_pend_in;
   wfa_pkg::idx_type                rd_idx_ff, rd_idx_in;
   logic                            found_ff, found_in;
   wfa_pkg::idx_type                best_idx_ff, best_idx_in;
   wfa_pkg::size_type               best_size_ff, best_size_in;
   wfa_pkg::size_type               ask_ff, ask_in;

   logic        accept;
   logic        take;
   logic        grant;
   logic [31:0] num;

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && !req_stall;

      ram_wr.en   = accept && (req_data.opcode == wfa_pkg::OP_LOAD)
                    && (count_ff < wfa_pkg::CNT_BITS'(wfa_pkg::MAX_BLOCKS));
      ram_wr.addr = count_ff[wfa_pkg::IDX_BITS-1:0];
      ram_wr.data = wfa_pkg::to_size(req_data.entry_size);
      ram_raddr   = scan_ff[wfa_pkg::IDX_BITS-1:0];

      take  = rd_pend_ff && !marks_ff[rd_idx_ff] && (!found_ff || ram_rdata > best_size_ff);
      grant = found_ff && (ask_ff <= best_size_ff);
      num   = 32'(best_idx_ff) + 32'd1;

      result.valid             = (state_ff == ST_FINISH) && out_free;
      result.data.granted      = grant;
      result.data.block_number = grant ? num[4:0] : 5'd0;
      result.data.block_size   = grant ? wfa_pkg::from_size(best_size_ff) : 16'd0;
      result.data.asked_size   = wfa_pkg::from_size(ask_ff);

      state_in     = state_ff;
      count_in     = count_ff;
      marks_in     = marks_ff;
      scan_in      = scan_ff;
      rd_pend_in   = (state_ff == ST_SCAN);
      rd_idx_in    = scan_ff[wfa_pkg::IDX_BITS-1:0];
      found_in     = found_ff || take;
      best_idx_in  = take ? rd_idx_ff : best_idx_ff;
      best_size_in = take ? ram_rdata : best_size_ff;
      ask_in       = ask_ff;

      if (ram_wr.en) begin
         marks_in[ram_wr.addr] = 1'b0;
         count_in = wfa_pkg::CNT_BITS'(count_ff + 1'b1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.opcode == wfa_pkg::OP_REQUEST) begin
               scan_in  = '0;
               found_in = 1'b0;
               ask_in   = wfa_pkg::to_size(req_data.request_size);
               state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = wfa_pkg::CNT_BITS'(scan_ff + 1'b1);
            if (wfa_pkg::CNT_BITS'(scan_ff + 1'b1) == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               if (grant) begin
                  marks_in[best_idx_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         marks_ff   <= '0;
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         marks_ff   <= marks_in;
         rd_pend_ff <= rd_pend_in;
         found_ff   <= found_in;
      end
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
      ask_ff       <= ask_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wfa_pkg::CNT_BITS'(wfa_pkg::MAX_BLOCKS))
      else $error("block count beyond capacity");

   a_read_loaded: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (wfa_pkg::CNT_BITS'(rd_idx_ff) < count_ff))
      else $error("scan read past loaded blocks");

   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.data.granted) |->
         (!marks_ff[best_idx_ff] && ask_ff <= best_size_ff))
      else $error("grant of allocated or undersized block");

   a_mark_set: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.data.granted) |=> marks_ff[$past(best_idx_ff)])
      else $error("granted block not marked");

endmodule
`default_nettype wire

// ===== rtl/core/worst_fit_block_allocator.sv =====
// Load beat: accepted while idle, no result; the next beat can be taken the cycle after.
// Request beat: one size-RAM read per loaded block (N), a drain state for the registered
// read data, then a finish state that decides; N = 0 goes straight to finish. The result
// is registered at the output. No new beat is taken until finish ends, so the serial scan
// sets the rate; a stalled result holds finish. Reset clears block count, allocation marks
// and output valid; the size RAM is not cleared, only loaded entries are considered.
`default_nettype none
module worst_fit_block_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire wfa_pkg::req_type req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output wfa_pkg::rsp_type      rsp_data,
   input  wire logic             rsp_stall
);

   wfa_pkg::ram_wr_type ram_wr;
   wfa_pkg::idx_type    ram_raddr;
   wfa_pkg::size_type   ram_rdata;
   wfa_pkg::res_type    result;
   logic                out_free;

   logic                rsp_valid_ff;
   wfa_pkg::rsp_type    rsp_data_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   wfa_size_ram u_ram (
      .clock (clock),
      .wr    (ram_wr),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_free  (out_free),
      .result    (result),
      .ram_wr    (ram_wr),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.valid) begin
         rsp_data_ff <= result.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
